>>> hdl/rmslm_pkg.sv
`default_nettype none

package rmslm_pkg;

  // Defaults for the top-level parameters.
  localparam int MAX_FRAMES_DEF  = 1024;
  localparam int SAMPLE_BITS_DEF = 16;

  // Field and register widths.
  localparam int CFG_W    = 11;
  localparam int LEVEL_W  = 15;
  localparam int COUNT_W  = 16;
  localparam int COEF_W   = 16;
  localparam int OUT_W    = ((2 * LEVEL_W + COUNT_W + 7) / 8) * 8;

  localparam logic [CFG_W-1:0] FPB_RESET = CFG_W'(256);

  // 0.93 and 0.07 in Q0.16.
  localparam logic [COEF_W-1:0] SMOOTH_OLD = COEF_W'(60948);
  localparam logic [COEF_W-1:0] SMOOTH_NEW = COEF_W'(4588);

  // Queue between the accumulator and the arithmetic back end.
  localparam int QUEUE_DEPTH = 2;

  // Register interface.
  localparam int APB_ADDR_W = 3;
  localparam int APB_DATA_W = 32;
  localparam int REG_IDX_W  = APB_ADDR_W - 2;
  localparam logic [REG_IDX_W-1:0] REG_FRAMES_PER_BUFFER = REG_IDX_W'(0);

  typedef enum logic [2:0] {
    BK_IDLE,
    BK_DIV,
    BK_SQRT,
    BK_MUL,
    BK_SUM
  } back_state_t;

endpackage

`default_nettype wire

>>> hdl/rmslm_fifo.sv
`default_nettype none

module rmslm_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2
) (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire logic                       push,
  input  wire logic [WIDTH-1:0]           push_data,
  input  wire logic                       pop,
  output logic      [WIDTH-1:0]           pop_data,
  output logic                            empty,
  output logic      [$clog2(DEPTH+1)-1:0] level
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int LVL_W = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] slots [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [LVL_W-1:0] fill;

  logic do_push;
  logic do_pop;

  assign do_push  = push && (fill != LVL_W'(DEPTH));
  assign do_pop   = pop && (fill != '0);
  assign pop_data = slots[rd_ptr];
  assign empty    = (fill == '0);
  assign level    = fill;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        fill <= fill + 1'b1;
      end else if (do_pop && !do_push) begin
        fill <= fill - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wr_ptr] <= push_data;
    end
  end

endmodule

`default_nettype wire

>>> hdl/rmslm_front.sv
`default_nettype none

module rmslm_front #(
  parameter int SAMPLE_BITS = rmslm_pkg::SAMPLE_BITS_DEF,
  parameter int MAX_FRAMES  = rmslm_pkg::MAX_FRAMES_DEF,
  parameter int SUM_W       = 42,
  parameter int CNT_W       = 11,
  parameter int QDEPTH      = rmslm_pkg::QUEUE_DEPTH
) (
  input  wire logic                             clk,
  input  wire logic                             rst,
  input  wire logic                             in_valid,
  output logic                                  in_ready,
  input  wire logic [SAMPLE_BITS-1:0]           sample_left,
  input  wire logic [SAMPLE_BITS-1:0]           sample_right,
  input  wire logic [rmslm_pkg::CFG_W-1:0]      frames_per_buffer,
  input  wire logic [$clog2(QDEPTH+1)-1:0]      queue_level,
  output logic                                  push,
  output logic      [SUM_W-1:0]                 push_sum,
  output logic      [CNT_W-1:0]                 push_frames
);

  localparam int SB    = SAMPLE_BITS;
  localparam int LVL_W = $clog2(QDEPTH + 1);
  localparam int CMP_W = (CNT_W > rmslm_pkg::CFG_W) ? CNT_W : rmslm_pkg::CFG_W;
  localparam logic [CMP_W-1:0] MAX_LEN = CMP_W'(MAX_FRAMES);

  logic [SB-1:0]    mag_l;
  logic [SB-1:0]    mag_r;
  logic [2*SB-1:0]  sq_l;
  logic [2*SB-1:0]  sq_r;
  logic             sq_valid;
  logic [SUM_W-1:0] square_sum;
  logic [CNT_W-1:0] frame_count;
  logic [SUM_W-1:0] square_sum_next;
  logic [CNT_W-1:0] frame_count_next;
  logic [CMP_W-1:0] fpb_ext;
  logic [CMP_W-1:0] len;
  logic             close;
  logic             accept;

  // The most negative sample has a magnitude that still fits as unsigned.
  assign mag_l = sample_left[SB-1]  ? SB'(~sample_left + 1'b1)  : sample_left;
  assign mag_r = sample_right[SB-1] ? SB'(~sample_right + 1'b1) : sample_right;

  // Leave room for the frame already in the squaring stage.
  assign in_ready = ((LVL_W+1)'(queue_level) + (LVL_W+1)'(sq_valid)) < (LVL_W+1)'(QDEPTH);
  assign accept   = in_valid && in_ready;

  assign fpb_ext = CMP_W'(frames_per_buffer);

  always_comb begin
    if (frames_per_buffer == '0) begin
      len = CMP_W'(1);
    end else if (fpb_ext > MAX_LEN) begin
      len = MAX_LEN;
    end else begin
      len = fpb_ext;
    end
  end

  assign square_sum_next  = square_sum + SUM_W'(sq_l) + SUM_W'(sq_r);
  assign frame_count_next = frame_count + 1'b1;
  assign close            = CMP_W'(frame_count_next) >= len;

  assign push        = sq_valid && close;
  assign push_sum    = square_sum_next;
  assign push_frames = frame_count_next;

  always_ff @(posedge clk) begin
    if (accept) begin
      sq_l <= mag_l * mag_l;
      sq_r <= mag_r * mag_r;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      sq_valid    <= 1'b0;
      square_sum  <= '0;
      frame_count <= '0;
    end else begin
      sq_valid <= accept;
      if (sq_valid) begin
        if (close) begin
          square_sum  <= '0;
          frame_count <= '0;
        end else begin
          square_sum  <= square_sum_next;
          frame_count <= frame_count_next;
        end
      end
    end
  end

endmodule

`default_nettype wire

>>> hdl/rmslm_back.sv
`default_nettype none

module rmslm_back #(
  parameter int SUM_W = 42,
  parameter int CNT_W = 11
) (
  input  wire logic                              clk,
  input  wire logic                              rst,
  input  wire logic                              job_ready,
  input  wire logic [SUM_W-1:0]                  job_sum,
  input  wire logic [CNT_W-1:0]                  job_frames,
  output logic                                   job_pop,
  output logic                                   out_valid,
  input  wire logic                              out_ready,
  output logic      [rmslm_pkg::LEVEL_W-1:0]     rms_level,
  output logic      [rmslm_pkg::LEVEL_W-1:0]     smoothed_level,
  output logic      [rmslm_pkg::COUNT_W-1:0]     buffer_count
);

  localparam int LW     = rmslm_pkg::LEVEL_W;
  localparam int CW     = rmslm_pkg::COEF_W;
  localparam int QW     = SUM_W - 3;
  localparam int ITER   = (QW + 1) / 2;
  localparam int RW     = 2 * ITER;
  localparam int STEP_W = $clog2(QW + 1);
  localparam int PROD_W = CW + LW;
  localparam logic [RW-1:0] BIT_INIT = RW'(1) << (RW - 2);

  rmslm_pkg::back_state_t state;
  rmslm_pkg::back_state_t state_next;

  logic [STEP_W-1:0] step;
  logic [QW-1:0]     div_q;
  logic [CNT_W-1:0]  div_r;
  logic [CNT_W-1:0]  div_n;
  logic [RW-1:0]     sq_res;
  logic [RW-1:0]     sq_bit;
  logic [PROD_W-1:0] prod_old;
  logic [PROD_W-1:0] prod_new;
  logic [LW-1:0]     rms_hold;
  logic [PROD_W:0]   smooth_sum;

  logic div_en;
  logic sq_en;
  logic mul_en;
  logic out_load;
  logic div_last;
  logic sq_last;

  logic [CNT_W:0] div_trial;
  logic           div_ge;
  logic [RW-1:0]  sq_trial;
  logic [RW-1:0]  sq_x;
  logic           sq_ge;

  assign div_last = (step == STEP_W'(QW - 1));
  assign sq_last  = (step == STEP_W'(ITER - 1));

  // Restoring division of sum/8 by the frame count, one quotient bit a cycle.
  // The dividend register shifts out from the top while quotient bits enter below.
  assign div_trial = {div_r, div_q[QW-1]};
  assign div_ge    = div_trial >= {1'b0, div_n};

  // Square root, two radicand bits a cycle; the quotient register holds the radicand.
  assign sq_x     = RW'(div_q);
  assign sq_trial = sq_res + sq_bit;
  assign sq_ge    = sq_x >= sq_trial;

  assign smooth_sum = (PROD_W+1)'(prod_old) + (PROD_W+1)'(prod_new);

  always_comb begin
    state_next = state;
    unique case (state)
      rmslm_pkg::BK_IDLE: if (job_ready) state_next = rmslm_pkg::BK_DIV;
      rmslm_pkg::BK_DIV:  if (div_last) state_next = rmslm_pkg::BK_SQRT;
      rmslm_pkg::BK_SQRT: if (sq_last) state_next = rmslm_pkg::BK_MUL;
      rmslm_pkg::BK_MUL:  state_next = rmslm_pkg::BK_SUM;
      rmslm_pkg::BK_SUM:  if (!out_valid || out_ready) state_next = rmslm_pkg::BK_IDLE;
      default:            state_next = rmslm_pkg::BK_IDLE;
    endcase
  end

  always_comb begin
    job_pop  = 1'b0;
    div_en   = 1'b0;
    sq_en    = 1'b0;
    mul_en   = 1'b0;
    out_load = 1'b0;
    unique case (state)
      rmslm_pkg::BK_IDLE: job_pop = job_ready;
      rmslm_pkg::BK_DIV:  div_en = 1'b1;
      rmslm_pkg::BK_SQRT: sq_en = 1'b1;
      rmslm_pkg::BK_MUL:  mul_en = 1'b1;
      rmslm_pkg::BK_SUM:  out_load = !out_valid || out_ready;
      default:            job_pop = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= rmslm_pkg::BK_IDLE;
      step           <= '0;
      out_valid      <= 1'b0;
      smoothed_level <= '0;
      buffer_count   <= '0;
    end else begin
      state <= state_next;
      if (job_pop || (div_en && div_last) || (sq_en && sq_last)) begin
        step <= '0;
      end else if (div_en || sq_en) begin
        step <= step + 1'b1;
      end
      if (out_load) begin
        out_valid      <= 1'b1;
        smoothed_level <= smooth_sum[CW +: LW];
        buffer_count   <= buffer_count + 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (job_pop) begin
      div_q <= job_sum[SUM_W-1:3];
      div_r <= '0;
      div_n <= job_frames;
    end else if (div_en) begin
      div_r <= div_ge ? CNT_W'(div_trial - {1'b0, div_n}) : div_trial[CNT_W-1:0];
      div_q <= {div_q[QW-2:0], div_ge};
    end else if (sq_en && sq_ge) begin
      div_q <= QW'(sq_x - sq_trial);
    end

    if (div_en && div_last) begin
      sq_res <= '0;
      sq_bit <= BIT_INIT;
    end else if (sq_en) begin
      sq_res <= sq_ge ? (sq_res >> 1) + sq_bit : sq_res >> 1;
      sq_bit <= sq_bit >> 2;
    end

    if (mul_en) begin
      rms_hold <= LW'(sq_res);
      prod_old <= PROD_W'(rmslm_pkg::SMOOTH_OLD) * PROD_W'(smoothed_level);
      prod_new <= PROD_W'(rmslm_pkg::SMOOTH_NEW) * PROD_W'(LW'(sq_res));
    end

    if (out_load) begin
      rms_level <= rms_hold;
    end
  end

endmodule

`default_nettype wire

>>> hdl/stereo_rms_level_meter.sv
`default_nettype none

// Stereo RMS level meter. Each input transaction is one stereo frame of two
// signed samples (left in the low half of s_tdata). After frames_per_buffer
// frames (0 acts as 1, values above MAX_FRAMES act as MAX_FRAMES) one output
// transaction carries the RMS of the halved samples over the buffer, the
// exponentially smoothed level (0.93 old, 0.07 new) and a wrapping buffer
// count. Frames are taken one per clock while the queue is empty; while it
// holds a buffer, a frame is taken only when none is in the squaring stage.
// The squares are registered and then accumulated. Each completed buffer is
// queued (two deep) for the back end, which takes it from the queue, divides
// it by the frame count (one quotient bit a cycle), takes the square root
// (two bits a cycle) and then smooths and outputs the level. The sum is
// SUM_W = 2*SAMPLE_BITS + clog2(MAX_FRAMES) bits wide, at most 64. Short
// buffers that finish faster than the back end works them off fill the queue
// and hold s_tready low.
// frames_per_buffer sits at byte address 0 of the register port and is only
// to be changed while no frame is in flight.
module stereo_rms_level_meter #(
  parameter int MAX_FRAMES  = rmslm_pkg::MAX_FRAMES_DEF,
  parameter int SAMPLE_BITS = rmslm_pkg::SAMPLE_BITS_DEF
) (
  input  wire logic                                   clk,
  input  wire logic                                   rst,
  // Frame input.
  input  wire logic                                   s_tvalid,
  output logic                                        s_tready,
  // sample_left, sample_right
  input  wire logic [((2*SAMPLE_BITS+7)/8)*8-1:0]     s_tdata,
  // Level output.
  output logic                                        m_tvalid,
  input  wire logic                                   m_tready,
  // rms_level, smoothed_level, buffer_count, zero pad
  output logic      [rmslm_pkg::OUT_W-1:0]            m_tdata,
  // Register port.
  input  wire logic                                   psel,
  input  wire logic                                   penable,
  input  wire logic                                   pwrite,
  input  wire logic [rmslm_pkg::APB_ADDR_W-1:0]       paddr,
  input  wire logic [rmslm_pkg::APB_DATA_W-1:0]       pwdata,
  output logic      [rmslm_pkg::APB_DATA_W-1:0]       prdata,
  output logic                                        pready
);

  localparam int SB     = SAMPLE_BITS;
  localparam int RAW_W  = 2 * SB + $clog2(MAX_FRAMES);
  localparam int SUM_W  = (RAW_W > 64) ? 64 : RAW_W;
  localparam int CNT_W  = $clog2(MAX_FRAMES + 1);
  localparam int QD     = rmslm_pkg::QUEUE_DEPTH;
  localparam int LVL_W  = $clog2(QD + 1);
  localparam int JOB_W  = SUM_W + CNT_W;
  localparam int LW     = rmslm_pkg::LEVEL_W;
  localparam int PAD_W  = rmslm_pkg::OUT_W - 2 * LW - rmslm_pkg::COUNT_W;

  logic [rmslm_pkg::CFG_W-1:0]     frames_per_buffer;
  logic [rmslm_pkg::REG_IDX_W-1:0] reg_idx;
  logic                            reg_write;

  logic             push;
  logic [SUM_W-1:0] push_sum;
  logic [CNT_W-1:0] push_frames;
  logic [JOB_W-1:0] job_data;
  logic             job_empty;
  logic             job_pop;
  logic [LVL_W-1:0] queue_level;

  logic [LW-1:0]                     rms_level;
  logic [LW-1:0]                     smoothed_level;
  logic [rmslm_pkg::COUNT_W-1:0]     buffer_count;

  assign pready    = 1'b1;
  assign reg_idx   = paddr[rmslm_pkg::APB_ADDR_W-1:2];
  assign reg_write = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      frames_per_buffer <= rmslm_pkg::FPB_RESET;
    end else if (reg_write && reg_idx == rmslm_pkg::REG_FRAMES_PER_BUFFER) begin
      frames_per_buffer <= pwdata[rmslm_pkg::CFG_W-1:0];
    end
  end

  always_comb begin
    prdata = '0;
    if (reg_idx == rmslm_pkg::REG_FRAMES_PER_BUFFER) begin
      prdata = rmslm_pkg::APB_DATA_W'(frames_per_buffer);
    end
  end

  rmslm_front #(
    .SAMPLE_BITS (SAMPLE_BITS),
    .MAX_FRAMES  (MAX_FRAMES),
    .SUM_W       (SUM_W),
    .CNT_W       (CNT_W),
    .QDEPTH      (QD)
  ) u_front (
    .clk               (clk),
    .rst               (rst),
    .in_valid          (s_tvalid),
    .in_ready          (s_tready),
    .sample_left       (s_tdata[SB-1:0]),
    .sample_right      (s_tdata[2*SB-1:SB]),
    .frames_per_buffer (frames_per_buffer),
    .queue_level       (queue_level),
    .push              (push),
    .push_sum          (push_sum),
    .push_frames       (push_frames)
  );

  rmslm_fifo #(
    .WIDTH (JOB_W),
    .DEPTH (QD)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data ({push_frames, push_sum}),
    .pop       (job_pop),
    .pop_data  (job_data),
    .empty     (job_empty),
    .level     (queue_level)
  );

  rmslm_back #(
    .SUM_W (SUM_W),
    .CNT_W (CNT_W)
  ) u_back (
    .clk            (clk),
    .rst            (rst),
    .job_ready      (!job_empty),
    .job_sum        (job_data[SUM_W-1:0]),
    .job_frames     (job_data[JOB_W-1:SUM_W]),
    .job_pop        (job_pop),
    .out_valid      (m_tvalid),
    .out_ready      (m_tready),
    .rms_level      (rms_level),
    .smoothed_level (smoothed_level),
    .buffer_count   (buffer_count)
  );

  assign m_tdata = {{PAD_W{1'b0}}, buffer_count, smoothed_level, rms_level};

endmodule

`default_nettype wire

>>> bench/stereo_rms_level_meter_test.sv
`timescale 1ns / 100ps

module stereo_rms_level_meter_test;

  localparam int SAMPLE_W      = rmslm_pkg::SAMPLE_BITS_DEF;
  localparam int IN_W          = ((2 * SAMPLE_W + 7) / 8) * 8;
  localparam int LEVEL_W       = rmslm_pkg::LEVEL_W;
  localparam int COUNT_W       = rmslm_pkg::COUNT_W;
  localparam int CFG_W         = rmslm_pkg::CFG_W;
  localparam int IDX_W         = rmslm_pkg::REG_IDX_W;
  localparam int DATA_W        = rmslm_pkg::APB_DATA_W;
  localparam int ITEM_TARGET   = 1950;
  localparam int SETTLE_CYCLES = 128;
  localparam int WATCHDOG_MAX  = 4000;
  localparam int LONG_HOLD     = 300;

  localparam logic [IDX_W-1:0] REG_FPB = rmslm_pkg::REG_FRAMES_PER_BUFFER;
  // Register index with nothing behind it; writes to it must be ignored.
  localparam logic [IDX_W-1:0] REG_SPARE = IDX_W'(1);

  typedef struct packed {
    logic [LEVEL_W-1:0] rms;
    logic [LEVEL_W-1:0] smoothed;
    logic [COUNT_W-1:0] count;
  } level_t;

  logic                             clk;
  logic                             rst;
  logic                             s_tvalid;
  logic                             s_tready;
  // sample_left, sample_right
  logic [IN_W-1:0]                  s_tdata;
  logic                             m_tvalid;
  logic                             m_tready;
  // rms_level, smoothed_level, buffer_count, zero pad
  logic [rmslm_pkg::OUT_W-1:0]      m_tdata;
  logic                             psel;
  logic                             penable;
  logic                             pwrite;
  logic [rmslm_pkg::APB_ADDR_W-1:0] paddr;
  logic [DATA_W-1:0]                pwdata;
  logic [DATA_W-1:0]                prdata;
  logic                             pready;

  // Predicted state of the meter.
  logic [CFG_W-1:0]   fpb_setting;
  logic [63:0]        meter_sum;
  int                 meter_frames;
  logic [LEVEL_W-1:0] meter_smoothed;
  logic [COUNT_W-1:0] meter_buffers;

  level_t expected_levels[$];
  int     error_count;
  int     frames_sent;
  int     levels_seen;
  int     settings_used;
  int     long_hold_cycles;
  int     idle_cycles;
  bit     quiet_source;
  bit     quiet_sink;

  stereo_rms_level_meter u_top (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic logic [63:0] sample_power(input logic signed [SAMPLE_W-1:0] s);
    longint v;
    v = s;
    return 64'(v * v);
  endfunction

  function automatic logic [63:0] floor_sqrt(input logic [63:0] x);
    logic [63:0] root;
    logic [63:0] trial;
    root = 0;
    for (int b = 31; b >= 0; b--) begin
      trial = root | (64'd1 << b);
      if (trial * trial <= x) root = trial;
    end
    return root;
  endfunction

  // Accumulates one frame and queues a level when the buffer closes.
  task automatic accumulate_frame(input logic signed [SAMPLE_W-1:0] left,
                                  input logic signed [SAMPLE_W-1:0] right);
    int          span;
    logic [63:0] mean;
    logic [63:0] blend;
    level_t      lvl;
    span = (fpb_setting == 0) ? 1 :
           (int'(fpb_setting) > rmslm_pkg::MAX_FRAMES_DEF) ? rmslm_pkg::MAX_FRAMES_DEF :
           int'(fpb_setting);
    meter_sum    = meter_sum + sample_power(left) + sample_power(right);
    meter_frames = meter_frames + 1;
    if (meter_frames >= span) begin
      mean           = meter_sum / (64'd8 * 64'(meter_frames));
      lvl.rms        = LEVEL_W'(floor_sqrt(mean));
      blend          = (64'(rmslm_pkg::SMOOTH_OLD) * 64'(meter_smoothed) +
                        64'(rmslm_pkg::SMOOTH_NEW) * 64'(lvl.rms)) >> 16;
      meter_smoothed = LEVEL_W'(blend);
      meter_buffers  = meter_buffers + 1'b1;
      lvl.smoothed   = meter_smoothed;
      lvl.count      = meter_buffers;
      expected_levels.insert(expected_levels.size(), lvl);
      meter_sum    = 0;
      meter_frames = 0;
    end
  endtask

  function automatic logic [SAMPLE_W-1:0] draw_sample();
    case ($urandom_range(0, 7))
      0: return 16'h8000;
      1: return 16'h7FFF;
      2: return SAMPLE_W'($urandom_range(0, 31)) - SAMPLE_W'(16);
      default: return SAMPLE_W'($urandom);
    endcase
  endfunction

  task automatic pick_idling();
    quiet_source = ($urandom_range(0, 3) == 0);
    quiet_sink   = ($urandom_range(0, 3) == 0);
  endtask

  // Offers one frame and returns at the edge where it is taken.
  task automatic send_frame(input logic [SAMPLE_W-1:0] left, input logic [SAMPLE_W-1:0] right);
    int gap;
    gap = quiet_source ? 0 : $urandom_range(0, 15);
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tdata  <= IN_W'({right, left});
    s_tvalid <= 1'b1;
    accumulate_frame(left, right);
    frames_sent++;
    do @(posedge clk); while (!s_tready);
  endtask

  // Waits for every queued level, then lets the back end go quiet.
  task automatic drain_levels();
    s_tvalid <= 1'b0;
    while (expected_levels.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic reg_write(input logic [IDX_W-1:0] idx, input logic [DATA_W-1:0] data);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= data;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    if (idx == REG_FPB) begin
      fpb_setting = data[CFG_W-1:0];
      settings_used++;
    end
  endtask

  task automatic reg_check(input logic [IDX_W-1:0] idx);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    paddr   <= {idx, 2'b00};
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    if (prdata[CFG_W-1:0] !== fpb_setting) begin
      $error("frames_per_buffer: expected %0d, actual %0d", fpb_setting, prdata[CFG_W-1:0]);
      error_count++;
    end
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  task automatic test_register_port();
    reg_check(REG_FPB);
    reg_write(REG_SPARE, 32'd5);
    reg_check(REG_FPB);
    reg_write(REG_FPB, 32'd1);
    reg_check(REG_FPB);
  endtask

  // One frame per buffer, so each extreme shows up directly in a level.
  task automatic test_sample_extremes();
    pick_idling();
    send_frame(16'h0000, 16'h0000);
    send_frame(16'h8000, 16'h8000);
    send_frame(16'h7FFF, 16'h7FFF);
    send_frame(16'h8000, 16'h7FFF);
    send_frame(16'h0001, 16'hFFFF);
    send_frame(16'hFFFF, 16'h0001);
    send_frame(16'h5555, 16'hAAAA);
    send_frame(16'hAAAA, 16'h5555);
    drain_levels();
  endtask

  // A length of zero must behave as a length of one.
  task automatic test_zero_length();
    reg_write(REG_FPB, 32'd0);
    pick_idling();
    repeat (3) send_frame(draw_sample(), draw_sample());
    drain_levels();
  endtask

  // Lowering the length below the frames already counted closes the buffer on
  // the next frame, divided by the true frame count.
  task automatic test_length_lowered();
    reg_write(REG_FPB, 32'd8);
    pick_idling();
    repeat (5) send_frame(draw_sample(), draw_sample());
    drain_levels();
    reg_write(REG_FPB, 32'd3);
    send_frame(draw_sample(), draw_sample());
    drain_levels();
    reg_write(REG_FPB, 32'd4);
    repeat (2) send_frame(draw_sample(), draw_sample());
    drain_levels();
    reg_write(REG_FPB, 32'd2);
    send_frame(draw_sample(), draw_sample());
    drain_levels();
  endtask

  // The largest register value is clamped to the longest buffer.
  task automatic test_longest_buffer();
    reg_write(REG_FPB, 32'd2047);
    reg_check(REG_FPB);
    pick_idling();
    repeat (rmslm_pkg::MAX_FRAMES_DEF) send_frame(draw_sample(), draw_sample());
    drain_levels();
  endtask

  // The sink stops for a long while so that the level queue fills and the
  // frame input is held off.
  task automatic test_back_pressure();
    reg_write(REG_FPB, 32'd1);
    quiet_source     = 1'b1;
    long_hold_cycles = LONG_HOLD;
    repeat (24) send_frame(draw_sample(), draw_sample());
    drain_levels();
  endtask

  task automatic test_random_buffers();
    int          burst;
    logic [31:0] length;
    while (frames_sent < ITEM_TARGET) begin
      case ($urandom_range(0, 9))
        0: length = 32'd0;
        1: length = ($urandom_range(0, 1) == 0) ? 32'd1024 : $urandom_range(1025, 2047);
        2: length = $urandom_range(17, 64);
        default: length = $urandom_range(1, 16);
      endcase
      if ($urandom_range(0, 7) == 0) reg_write(REG_SPARE, $urandom);
      reg_write(REG_FPB, length);
      pick_idling();
      burst = $urandom_range(1, 60);
      repeat (burst) send_frame(draw_sample(), draw_sample());
      drain_levels();
    end
  endtask

  initial begin
    rst              <= 1'b1;
    s_tvalid         <= 1'b0;
    s_tdata          <= '0;
    psel             <= 1'b0;
    penable          <= 1'b0;
    pwrite           <= 1'b0;
    paddr            <= '0;
    pwdata           <= '0;
    fpb_setting      = rmslm_pkg::FPB_RESET;
    meter_sum        = 0;
    meter_frames     = 0;
    meter_smoothed   = '0;
    meter_buffers    = '0;
    error_count      = 0;
    frames_sent      = 0;
    settings_used    = 0;
    long_hold_cycles = 0;
    quiet_source     = 1'b0;
    quiet_sink       = 1'b0;
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    test_register_port();
    test_sample_extremes();
    test_zero_length();
    test_length_lowered();
    test_longest_buffer();
    test_back_pressure();
    test_random_buffers();

    $display("Sent %0d stereo frames and checked %0d level results", frames_sent, levels_seen);
    $display("across %0d buffer-length settings, including zero and oversized lengths.",
             settings_used);
    if (error_count == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

  // Result sink: a random pause before each transaction, or a long hold when
  // one has been requested.
  initial begin : level_sink
    int pause;
    m_tready <= 1'b0;
    @(posedge clk);
    while (rst) @(posedge clk);
    forever begin
      if (long_hold_cycles > 0) begin
        pause            = long_hold_cycles;
        long_hold_cycles = 0;
      end else begin
        pause = quiet_sink ? 0 : $urandom_range(0, 15);
      end
      if (pause > 0) begin
        m_tready <= 1'b0;
        repeat (pause) @(posedge clk);
      end
      m_tready <= 1'b1;
      do @(posedge clk); while (!(m_tvalid && m_tready));
    end
  end

  always @(posedge clk) begin : level_check
    level_t want;
    if (rst) begin
      levels_seen <= 0;
    end else if (m_tvalid && m_tready) begin
      levels_seen <= levels_seen + 1;
      if (expected_levels.size() == 0) begin
        $error("level result with none expected: %h", m_tdata);
        error_count++;
      end else begin
        want = expected_levels.pop_front();
        if (m_tdata[LEVEL_W-1:0] !== want.rms) begin
          $error("rms_level: expected %0d, actual %0d", want.rms, m_tdata[LEVEL_W-1:0]);
          error_count++;
        end
        if (m_tdata[2*LEVEL_W-1:LEVEL_W] !== want.smoothed) begin
          $error("smoothed_level: expected %0d, actual %0d", want.smoothed,
                 m_tdata[2*LEVEL_W-1:LEVEL_W]);
          error_count++;
        end
        if (m_tdata[2*LEVEL_W+COUNT_W-1:2*LEVEL_W] !== want.count) begin
          $error("buffer_count: expected %0d, actual %0d", want.count,
                 m_tdata[2*LEVEL_W+COUNT_W-1:2*LEVEL_W]);
          error_count++;
        end
      end
    end
  end

  // Ends the run if no transaction of any kind completes for too long.
  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready) || (psel && penable)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_MAX) begin
        $display("SCOREBOARD MISMATCH");
        $finish;
      end
    end
  end

endmodule
